// ===== rtl/core/whc_pkg.sv =====
// Shared types and constants for the WireGuard header classifier.
`default_nettype none

package whc_pkg;

   // Number of payload length bits that take part in the size checks.
   localparam int LENGTH_WIDTH = 16;

   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam int          SIZE_INIT       = 148;
   localparam int          SIZE_RESPONSE   = 92;
   localparam int          SIZE_COOKIE     = 64;
   localparam int          SIZE_DATA_MIN   = 32;
   localparam logic [31:0] DNS_PATTERN     = 32'h0001_0000;
   localparam logic [6:0]  LEVEL_NONE      = 7'd0;
   localparam logic [6:0]  LEVEL_DNS       = 7'd1;
   localparam logic [6:0]  LEVEL_WG        = 7'd100;

   // Message type codes as they appear in the first payload byte.
   localparam logic [7:0]  TYPE_INIT       = 8'd1;
   localparam logic [7:0]  TYPE_RESPONSE   = 8'd2;
   localparam logic [7:0]  TYPE_COOKIE     = 8'd3;
   localparam logic [7:0]  TYPE_DATA       = 8'd4;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_FLUSH = 2'd1,
      ACT_TRIM  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MSG_INIT,
      MSG_RESPONSE,
      MSG_COOKIE,
      MSG_DATA
   } msg_type;

   // Stateless verdict of the front part for one item.
   typedef struct packed {
      logic        first_packet;
      logic        udp_ok;
      logic        direction;
      logic        wg_ok;
      msg_type     msg;
      logic        dns_like;
      logic [31:0] sender;
      logic [31:0] receiver;
   } cls_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  confidence;
      logic [31:0] forward_peer;
      logic        forward_valid;
      logic [31:0] reverse_peer;
      logic        reverse_valid;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/whc_front.sv =====
// Front part: classifies each header and queues the verdict for the back part.
`default_nettype none

module whc_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  wire                  req_first_packet,
   input  wire  [7:0]           req_l4_protocol,
   input  wire                  req_direction,
   input  wire  [15:0]          req_payload_length,
   input  wire  [31:0]          req_header_word0,
   input  wire  [31:0]          req_header_word1,
   input  wire  [31:0]          req_header_word2,
   output logic                 cls_valid,
   input  wire                  cls_take,
   output whc_pkg::cls_type     cls_item
);
   import whc_pkg::*;

   logic [LENGTH_WIDTH-1:0] len;
   logic [7:0]              type_byte;
   logic                    size_ok;
   msg_type                 msg;
   cls_type                 cls_new;
   logic                    push_ok;

   cls_type                 queue_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;

   assign len       = LENGTH_WIDTH'(req_payload_length);
   assign type_byte = req_header_word0[31:24];

   // Decode the message type and its size rule.
   always_comb begin
      msg     = MSG_DATA;
      size_ok = 1'b0;
      case (type_byte)
         TYPE_INIT: begin
            msg     = MSG_INIT;
            size_ok = (len == LENGTH_WIDTH'(SIZE_INIT));
         end
         TYPE_RESPONSE: begin
            msg     = MSG_RESPONSE;
            size_ok = (len == LENGTH_WIDTH'(SIZE_RESPONSE));
         end
         TYPE_COOKIE: begin
            msg     = MSG_COOKIE;
            size_ok = (len == LENGTH_WIDTH'(SIZE_COOKIE));
         end
         TYPE_DATA: begin
            msg     = MSG_DATA;
            size_ok = (len >= LENGTH_WIDTH'(SIZE_DATA_MIN));
         end
         default: begin
            msg     = MSG_DATA;
            size_ok = 1'b0;
         end
      endcase
   end

   // Assemble the verdict for this item.
   always_comb begin
      cls_new.first_packet = req_first_packet;
      cls_new.udp_ok       = (req_l4_protocol == PROTO_UDP);
      cls_new.direction    = req_direction;
      cls_new.wg_ok        = size_ok && (req_header_word0[23:0] == 24'd0);
      cls_new.msg          = msg;
      cls_new.dns_like     = (req_header_word1 == DNS_PATTERN);
      cls_new.sender       = req_header_word1;
      cls_new.receiver     = req_header_word2;
   end

   // Two-entry queue toward the back part.
   assign req_full  = (count_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cls_valid = (count_ff != 2'd0);
   assign cls_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cls_take;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, cls_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= cls_new;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/whc_back.sv =====
// Back part: applies verdicts to the peer state and queues the result items.
`default_nettype none

module whc_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  cls_valid,
   output logic                 cls_take,
   input  whc_pkg::cls_type     cls_item,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output whc_pkg::rsp_type     rsp_item
);
   import whc_pkg::*;

   logic [31:0] peer_ff [2];
   logic [31:0] peer_in [2];
   logic [1:0]  known_ff, known_in;
   logic [6:0]  level_ff, level_in;

   logic [31:0] peer_base [2];
   logic [1:0]  known_base;
   logic [6:0]  level_base;
   logic        dir;
   action_type  act;
   rsp_type     rsp_new;
   logic        pop_ok;

   rsp_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign dir      = cls_item.direction;
   assign cls_take = cls_valid && (count_ff != 2'd2);

   // A flow's first packet starts from cleared state.
   always_comb begin
      if (cls_item.first_packet) begin
         peer_base[0] = 32'd0;
         peer_base[1] = 32'd0;
         known_base   = 2'b00;
         level_base   = LEVEL_NONE;
      end else begin
         peer_base[0] = peer_ff[0];
         peer_base[1] = peer_ff[1];
         known_base   = known_ff;
         level_base   = level_ff;
      end
   end

   // Next peer state, confidence and action for the item at the queue head.
   always_comb begin
      peer_in[0] = peer_base[0];
      peer_in[1] = peer_base[1];
      known_in   = known_base;
      level_in   = level_base;
      act        = ACT_NONE;
      if (cls_item.first_packet && !cls_item.udp_ok) begin
         act = ACT_NONE;
      end else if (!cls_item.wg_ok) begin
         level_in = LEVEL_NONE;
      end else if (cls_item.msg == MSG_INIT && known_base[dir] &&
                   peer_base[dir] != cls_item.sender) begin
         act = ACT_FLUSH;
      end else begin
         peer_in[dir]  = cls_item.sender;
         known_in[dir] = 1'b1;
         if (cls_item.msg == MSG_RESPONSE) begin
            peer_in[!dir]  = cls_item.receiver;
            known_in[!dir] = 1'b1;
         end
         if (cls_item.dns_like) begin
            level_in = LEVEL_DNS;
            act      = ACT_NONE;
         end else begin
            level_in = LEVEL_WG;
            act      = ACT_TRIM;
         end
      end
   end

   // Result item reports the state after this item.
   always_comb begin
      rsp_new.action        = act;
      rsp_new.confidence    = level_in;
      rsp_new.forward_peer  = peer_in[0];
      rsp_new.forward_valid = known_in[0];
      rsp_new.reverse_peer  = peer_in[1];
      rsp_new.reverse_valid = known_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_ff[0] <= 32'd0;
         peer_ff[1] <= 32'd0;
         known_ff   <= 2'b00;
         level_ff   <= LEVEL_NONE;
      end else if (cls_take) begin
         peer_ff[0] <= peer_in[0];
         peer_ff[1] <= peer_in[1];
         known_ff   <= known_in;
         level_ff   <= level_in;
      end
   end

   // Two-entry result queue; the head drives the result ports.
   assign rsp_empty = (count_ff == 2'd0);
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ cls_take;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + {1'b0, cls_take} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_take) begin
         queue_ff[wr_ptr_ff] <= rsp_new;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/wireguard_header_classifier.sv =====
// Top level of the WireGuard header classifier.
//
// Both channels behave like queues. An input item (one UDP header) is taken
// at a clock edge where req_push is high and req_full is low. A result item
// sits on the rsp_ ports while rsp_empty is low and leaves at an edge where
// rsp_pop is high. Every input item gives exactly one result item, in order.
//
// An item taken at the input is classified and stored in a two-entry queue;
// the back part then applies it to the peer state and stores its result in
// the result queue, whose head drives the rsp_ ports. Throughput is one item
// per cycle while the receiver keeps popping, limited by the single peer-state
// update per cycle.
// When the receiver stalls, the result queue (two entries) fills, the back
// part stops draining, and req_full rises once the front queue (two entries)
// is full too. Up to four items can be held inside.
//
// Synchronous reset empties both queues and clears both peer indexes, their
// valid bits and the confidence value.
`default_nettype none

module wireguard_header_classifier (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_push,
   output logic        req_full,
   input  wire         req_first_packet,
   input  wire  [7:0]  req_l4_protocol,
   input  wire         req_direction,
   input  wire  [15:0] req_payload_length,
   input  wire  [31:0] req_header_word0,
   input  wire  [31:0] req_header_word1,
   input  wire  [31:0] req_header_word2,
   output logic        rsp_empty,
   input  wire         rsp_pop,
   output logic [1:0]  rsp_action,
   output logic [6:0]  rsp_confidence,
   output logic [31:0] rsp_forward_peer,
   output logic        rsp_forward_valid,
   output logic [31:0] rsp_reverse_peer,
   output logic        rsp_reverse_valid
);
   import whc_pkg::*;

   logic    cls_valid;
   logic    cls_take;
   cls_type cls_item;
   rsp_type rsp_item;

   whc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_first_packet   (req_first_packet),
      .req_l4_protocol    (req_l4_protocol),
      .req_direction      (req_direction),
      .req_payload_length (req_payload_length),
      .req_header_word0   (req_header_word0),
      .req_header_word1   (req_header_word1),
      .req_header_word2   (req_header_word2),
      .cls_valid          (cls_valid),
      .cls_take           (cls_take),
      .cls_item           (cls_item)
   );

   whc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls_take  (cls_take),
      .cls_item  (cls_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   // Unpack the head result item onto its ports.
   assign rsp_action        = rsp_item.action;
   assign rsp_confidence    = rsp_item.confidence;
   assign rsp_forward_peer  = rsp_item.forward_peer;
   assign rsp_forward_valid = rsp_item.forward_valid;
   assign rsp_reverse_peer  = rsp_item.reverse_peer;
   assign rsp_reverse_valid = rsp_item.reverse_valid;

endmodule

`default_nettype wire

// ===== rtl/core/whc_checker.sv =====
// Port-level checks for the WireGuard header classifier, bound to the top level.
`default_nettype none

module whc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_full,
   input wire        rsp_empty,
   input wire        rsp_pop,
   input wire [1:0]  rsp_action,
   input wire [6:0]  rsp_confidence,
   input wire [31:0] rsp_forward_peer,
   input wire        rsp_forward_valid,
   input wire [31:0] rsp_reverse_peer,
   input wire        rsp_reverse_valid
);

   // Reset leaves no result item waiting and the input open.
   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A waiting item that is not taken stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_action) && $stable(rsp_confidence) &&
          $stable(rsp_forward_peer) && $stable(rsp_reverse_peer)))
      else $error("stalled result item changed");

   // Confidence takes only its three defined levels.
   a_level: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_confidence == 7'd0 || rsp_confidence == 7'd1 ||
                      rsp_confidence == 7'd100))
      else $error("confidence out of its level set");

   // The unused action code never appears.
   a_action: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_action != 2'd3))
      else $error("undefined action code");

   // A peer that was never learned reads as zero.
   a_peer_clear: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_forward_valid || rsp_forward_peer == 32'd0) &&
                      (rsp_reverse_valid || rsp_reverse_peer == 32'd0)))
      else $error("unlearned peer index not zero");

endmodule

bind wireguard_header_classifier whc_checker u_whc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_action        (rsp_action),
   .rsp_confidence    (rsp_confidence),
   .rsp_forward_peer  (rsp_forward_peer),
   .rsp_forward_valid (rsp_forward_valid),
   .rsp_reverse_peer  (rsp_reverse_peer),
   .rsp_reverse_valid (rsp_reverse_valid)
);

`default_nettype wire
